>>> sv/smtr_pkg.sv
package smtr_pkg;

    localparam logic [2:0] ACT_ADD       = 3'd0;
    localparam logic [2:0] ACT_REMOVE    = 3'd1;
    localparam logic [2:0] ACT_ROUTE_PRI = 3'd2;
    localparam logic [2:0] ACT_ROUTE_SEC = 3'd3;
    localparam logic [2:0] ACT_COUNT     = 3'd4;
    localparam logic [2:0] ACT_NUM_TO_ID = 3'd5;
    localparam logic [2:0] ACT_ID_TO_NUM = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic [1:0] GRP_ALL = 2'd0;
    localparam logic [1:0] GRP_A   = 2'd1;
    localparam logic [1:0] GRP_B   = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] member_id;
        logic [1:0]  group;
        logic [31:0] sequence_req;
        logic [7:0]  position;
        logic        is_running;
        logic        name_match;
    } t_req;

    typedef struct packed {
        logic [31:0] chosen_id;
        logic [5:0]  rank;
        logic [6:0]  member_count;
        logic [2:0]  status;
    } t_rsp;

endpackage

>>> sv/sorted_member_table_modulo_router_core.sv
// Channel | Ports                     | Transfer
// request | i_start, o_busy, i_req    | start high while busy low
// result  | o_done, o_rsp             | done high for one cycle
// One item at a time. A table search reads, then compares, each entry it
// passes; a shift steps each entry it moves through S_MWR, S_MRD, S_LWT.
// A route waits on the shared remainder divider before its table read.
// Reset clears the counts, state and strobes; table contents are never read before written.
// The receiver cannot stall; o_busy stays high through the result cycle.
module sorted_member_table_modulo_router_core import smtr_pkg::*; #(
    parameter int MAX_MEMBERS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);
    localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_MEMBERS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;  // issue search read
    localparam logic [3:0] S_SCMP  = 4'd2;  // compare search data
    localparam logic [3:0] S_DEC   = 4'd3;  // decide after searches
    localparam logic [3:0] S_MRD   = 4'd4;  // shift read
    localparam logic [3:0] S_MWR   = 4'd5;  // shift write
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_LRD   = 4'd7;  // final table read
    localparam logic [3:0] S_LWT   = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    // Three tables in one memory, row = table index.
    logic [31:0] r_mem [3][MAX_MEMBERS];
    logic [31:0] r_rdata;
    logic [1:0]  w_rtab;
    logic [AW-1:0] w_raddr;
    logic        w_we;
    logic [1:0]  w_wtab;
    logic [AW-1:0] w_waddr;
    logic [31:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wtab][w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_rtab][w_raddr];
    end

    logic [3:0]    r_state;
    t_req          r_req;
    logic [CW-1:0] r_cnt [3];
    logic [1:0]    r_tab;       // table being searched or shifted
    logic          r_pass2;     // second table (all) handled
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_pos [2];   // lower position, [0]=group, [1]=all
    logic          r_hit [2];
    logic [CW-1:0] r_shift;
    logic [2:0]    r_status;
    logic [31:0]   r_chosen;
    logic [5:0]    r_rank;
    logic          r_div_go;
    logic          w_div_done;
    logic [CW-1:0] w_rem;

    logic [1:0] w_gtab;
    logic       w_grp;
    assign w_grp  = (r_req.group == GRP_A) || (r_req.group == GRP_B);
    assign w_gtab = w_grp ? r_req.group : GRP_ALL;

    smtr_divider #(.CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend ((r_req.action == ACT_ROUTE_SEC) ? r_req.sequence_req + 32'd1
                                                      : r_req.sequence_req),
        .i_divisor  (r_cnt[w_gtab]),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    logic w_slot;
    assign w_slot = (r_tab == GRP_ALL) ? 1'b1 : 1'b0;
    logic w_modify;  // add and remove touch both tables
    assign w_modify = (r_req.action == ACT_ADD) || (r_req.action == ACT_REMOVE);

    // Next table op after finishing one table: group first, then all.
    logic w_tab_act;   // does the current table need a shift
    assign w_tab_act = (r_req.action == ACT_ADD) ? !r_hit[w_slot] : r_hit[w_slot];

    // Memory port steering.
    always_comb begin
        w_rtab  = r_tab;
        w_raddr = r_idx[AW-1:0];
        w_we    = 1'b0;
        w_wtab  = r_tab;
        w_waddr = r_idx[AW-1:0];
        w_wdata = r_rdata;
        case (r_state)
            S_MRD: begin
                if (r_req.action == ACT_ADD) begin
                    w_raddr = AW'(r_shift - CW'(1));
                end else begin
                    w_raddr = AW'(r_shift + CW'(1));
                end
            end
            S_MWR: begin
                if ((r_req.action == ACT_ADD) && w_tab_act &&
                    (r_shift == r_pos[w_slot])) begin
                    w_we    = 1'b1;
                    w_waddr = r_shift[AW-1:0];
                    w_wdata = r_req.member_id;
                end
            end
            S_LWT: begin
                // The neighbor read in the previous cycle moves into this slot.
                if (w_modify) begin
                    w_we    = 1'b1;
                    w_waddr = r_shift[AW-1:0];
                end
            end
            S_LRD: begin
                w_rtab = w_gtab;
                if (r_req.action == ACT_NUM_TO_ID) begin
                    w_raddr = AW'(r_req.position);
                end else begin
                    w_raddr = w_rem[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Decision after both searches.
    logic w_need_all, w_need_g, w_full;
    assign w_need_all = !r_hit[1];
    assign w_need_g   = w_grp && !r_hit[0];
    assign w_full     = (w_need_all && (r_cnt[GRP_ALL] >= MAXC)) ||
                        (w_need_g && (r_cnt[w_gtab] >= MAXC));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_cnt[2] <= '0;
            o_done   <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            o_done   <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start && !o_busy) begin
                        r_req    <= i_req;
                        r_status <= ST_OK;
                        r_chosen <= '0;
                        r_rank   <= '0;
                        r_hit[0] <= 1'b0;
                        r_hit[1] <= 1'b0;
                        r_pos[0] <= '0;
                        r_pos[1] <= '0;
                        r_idx    <= '0;
                        r_pass2  <= 1'b0;
                        case (i_req.action)
                            ACT_ADD, ACT_REMOVE: begin
                                if (!i_req.name_match ||
                                    (i_req.action == ACT_ADD && !i_req.is_running)) begin
                                    r_status <= ST_IGNORED;
                                    r_state  <= S_RESP;
                                end else if ((i_req.group == GRP_A) ||
                                             (i_req.group == GRP_B)) begin
                                    r_tab   <= i_req.group;
                                    r_state <= S_SRD;
                                end else begin
                                    r_tab   <= GRP_ALL;
                                    r_pass2 <= 1'b1;
                                    r_state <= S_SRD;
                                end
                            end
                            ACT_ID_TO_NUM: begin
                                r_tab   <= ((i_req.group == GRP_A) ||
                                            (i_req.group == GRP_B)) ? i_req.group : GRP_ALL;
                                r_pass2 <= 1'b1;
                                r_state <= S_SRD;
                            end
                            ACT_ROUTE_PRI, ACT_ROUTE_SEC, ACT_NUM_TO_ID, ACT_COUNT: begin
                                r_state <= S_DEC;
                            end
                            default: begin
                                r_status <= ST_IGNORED;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SRD: begin
                    if (r_idx >= r_cnt[r_tab]) begin
                        r_pos[w_slot] <= r_idx;
                        r_hit[w_slot] <= 1'b0;
                        if (r_pass2) begin
                            r_state <= S_DEC;
                        end else begin
                            r_pass2 <= 1'b1;
                            r_tab   <= GRP_ALL;
                            r_idx   <= '0;
                        end
                    end else begin
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (r_rdata >= r_req.member_id) begin
                        r_pos[w_slot] <= r_idx;
                        r_hit[w_slot] <= (r_rdata == r_req.member_id);
                        if (r_pass2) begin
                            r_state <= S_DEC;
                        end else begin
                            r_pass2 <= 1'b1;
                            r_tab   <= GRP_ALL;
                            r_idx   <= '0;
                            r_state <= S_SRD;
                        end
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_DEC: begin
                    r_state <= S_RESP;
                    case (r_req.action)
                        ACT_ADD: begin
                            if (w_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_tab   <= w_gtab;
                                r_pass2 <= !w_grp;
                                r_shift <= r_cnt[w_gtab];
                                r_state <= S_MWR;
                            end
                        end
                        ACT_REMOVE: begin
                            if (!r_hit[1] && !(w_grp && r_hit[0])) begin
                                r_status <= ST_NOTFOUND;
                            end else begin
                                r_tab   <= w_gtab;
                                r_pass2 <= !w_grp;
                                r_shift <= r_pos[w_grp ? 1'b0 : 1'b1];
                                r_state <= S_MWR;
                            end
                        end
                        ACT_ROUTE_PRI, ACT_ROUTE_SEC: begin
                            if (r_cnt[w_gtab] == '0) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_div_go <= 1'b1;
                                r_state  <= S_DIV;
                            end
                        end
                        ACT_NUM_TO_ID: begin
                            if ({1'b0, r_req.position} < 9'(r_cnt[w_gtab])) begin
                                r_state <= S_LRD;
                            end else begin
                                r_status <= ST_NOTFOUND;
                            end
                        end
                        ACT_ID_TO_NUM: begin
                            if (r_hit[w_slot]) begin
                                r_rank <= 6'(r_pos[w_slot]);
                            end else begin
                                r_status <= ST_NOTFOUND;
                            end
                        end
                        default: ;
                    endcase
                end
                // S_MWR is the shift engine: for an add it walks down from
                // the count to the insert point, for a remove up to count-1.
                // The skip at entry to a table that needs no change is here.
                S_MWR: begin
                    if (!w_tab_act) begin
                        if (r_pass2) begin
                            r_state <= S_RESP;
                        end else begin
                            r_pass2 <= 1'b1;
                            r_tab   <= GRP_ALL;
                            r_shift <= (r_req.action == ACT_ADD) ? r_cnt[GRP_ALL] : r_pos[1];
                        end
                    end else if ((r_req.action == ACT_ADD) ? (r_shift == r_pos[w_slot])
                                 : (r_shift + CW'(1) >= r_cnt[r_tab])) begin
                        // Final step: the write in this cycle is the id or is
                        // suppressed for a remove at the tail.
                        r_cnt[r_tab] <= (r_req.action == ACT_ADD) ? r_cnt[r_tab] + CW'(1)
                                                                  : r_cnt[r_tab] - CW'(1);
                        r_hit[w_slot] <= (r_req.action == ACT_ADD);
                        if (r_pass2) begin
                            r_state <= S_RESP;
                        end else begin
                            r_pass2 <= 1'b1;
                            r_tab   <= GRP_ALL;
                            r_shift <= (r_req.action == ACT_ADD) ? r_cnt[GRP_ALL] : r_pos[1];
                        end
                    end else begin
                        r_state <= S_MRD;
                    end
                end
                S_MRD: begin
                    r_state <= S_LWT;
                end
                S_LWT: begin
                    if (r_req.action == ACT_NUM_TO_ID || r_req.action == ACT_ROUTE_PRI ||
                        r_req.action == ACT_ROUTE_SEC) begin
                        r_chosen <= r_rdata;
                        r_state  <= S_RESP;
                    end else begin
                        r_shift <= (r_req.action == ACT_ADD) ? r_shift - CW'(1)
                                                             : r_shift + CW'(1);
                        r_state <= S_MWR;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_LRD;
                    end
                end
                S_LRD: begin
                    r_state <= S_LWT;
                end
                S_RESP: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy             = (r_state != S_IDLE) || o_done;
    assign o_rsp.chosen_id    = r_chosen;
    assign o_rsp.rank         = r_rank;
    assign o_rsp.member_count = 7'(r_cnt[w_gtab]);
    assign o_rsp.status       = r_status;
endmodule

>>> sv/smtr_divider.sv
module smtr_divider import smtr_pkg::*; #(
    parameter int CW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [CW-1:0] o_rem
);
    // Restoring division, one quotient bit per cycle; only the remainder is kept.
    logic [31:0]   r_quo;
    logic [CW:0]   r_rem;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic [CW:0]   w_shift;

    assign w_shift = {r_rem[CW-1:0], r_quo[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quo <= {r_quo[30:0], 1'b0};
                if (w_shift >= {1'b0, i_divisor}) begin
                    r_rem <= w_shift - {1'b0, i_divisor};
                end else begin
                    r_rem <= w_shift;
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem[CW-1:0];
endmodule

>>> sim/sorted_member_table_modulo_router_core_tb.sv
module sorted_member_table_modulo_router_core_tb;
    import smtr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam int NUM_RANDOM  = 300;
    localparam logic [2:0] ACT_BAD = 3'd7;
    localparam logic [1:0] GRP_BAD = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    sorted_member_table_modulo_router_core #(.MAX_MEMBERS(TABLE_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // Model state: one table per group index, all members at index 0.
    logic [31:0] member_tbl [3][TABLE_DEPTH];
    int          member_cnt [3];

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   mismatch_count;
    int   transfer_count;
    int   result_count;
    bit   hold_off;
    bit   no_idle;
    int   status_seen [8];

    function automatic int find_pos(int g, logic [31:0] id);
        int i;
        i = 0;
        while (i < member_cnt[g] && member_tbl[g][i] < id) i++;
        return i;
    endfunction

    function automatic bit holds_id(int g, logic [31:0] id);
        int p;
        p = find_pos(g, id);
        return p < member_cnt[g] && member_tbl[g][p] == id;
    endfunction

    function automatic void insert_member(int g, logic [31:0] id);
        int p;
        p = find_pos(g, id);
        if ((p < member_cnt[g] && member_tbl[g][p] == id) || member_cnt[g] >= TABLE_DEPTH)
            return;
        for (int i = member_cnt[g]; i > p; i--) member_tbl[g][i] = member_tbl[g][i-1];
        member_tbl[g][p] = id;
        member_cnt[g]++;
    endfunction

    function automatic bit erase_member(int g, logic [31:0] id);
        int p;
        p = find_pos(g, id);
        if (p >= member_cnt[g] || member_tbl[g][p] != id) return 0;
        for (int i = p; i < member_cnt[g] - 1; i++) member_tbl[g][i] = member_tbl[g][i+1];
        member_cnt[g]--;
        return 1;
    endfunction

    function automatic t_rsp predict_routing(t_req r);
        t_rsp        rsp;
        int          g;
        bit          grp;
        bit          need_all;
        bit          need_g;
        bit          hit;
        logic [31:0] key;
        int          p;
        grp = (r.group == GRP_A || r.group == GRP_B);
        g   = grp ? int'(r.group) : 0;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.action)
            ACT_ADD: begin
                if (!r.is_running || !r.name_match) begin
                    rsp.status = ST_IGNORED;
                end else begin
                    need_all = !holds_id(0, r.member_id);
                    need_g   = grp && !holds_id(g, r.member_id);
                    if ((need_all && member_cnt[0] >= TABLE_DEPTH) ||
                        (need_g && member_cnt[g] >= TABLE_DEPTH)) begin
                        rsp.status = ST_FULL;
                    end else begin
                        if (grp) insert_member(g, r.member_id);
                        insert_member(0, r.member_id);
                    end
                end
            end
            ACT_REMOVE: begin
                if (!r.name_match) begin
                    rsp.status = ST_IGNORED;
                end else begin
                    hit = 0;
                    if (grp) hit = erase_member(g, r.member_id);
                    if (erase_member(0, r.member_id)) hit = 1;
                    rsp.status = hit ? ST_OK : ST_NOTFOUND;
                end
            end
            ACT_ROUTE_PRI, ACT_ROUTE_SEC: begin
                if (member_cnt[g] == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    key = (r.action == ACT_ROUTE_SEC) ? r.sequence_req + 32'd1 : r.sequence_req;
                    rsp.chosen_id = member_tbl[g][key % member_cnt[g]];
                end
            end
            ACT_COUNT: ;
            ACT_NUM_TO_ID: begin
                if (r.position < member_cnt[g]) rsp.chosen_id = member_tbl[g][r.position];
                else rsp.status = ST_NOTFOUND;
            end
            ACT_ID_TO_NUM: begin
                p = find_pos(g, r.member_id);
                if (p < member_cnt[g] && member_tbl[g][p] == r.member_id) rsp.rank = p[5:0];
                else rsp.status = ST_NOTFOUND;
            end
            default: rsp.status = ST_IGNORED;
        endcase
        rsp.member_count = member_cnt[g][6:0];
        return rsp;
    endfunction

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Driver: start stays high across back-to-back transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_req   <= '0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) begin
                expected_rsps.push_back(predict_routing(i_req));
                transfer_count++;
            end
            if (pending_reqs.size() > 0 && !hold_off &&
                (no_idle || $urandom_range(99) >= 7)) begin
                i_req   <= pending_reqs.pop_front();
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: a result is accepted at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_done) begin
            result_count++;
            if (expected_rsps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("ERROR: result with nothing expected: %p", o_rsp);
            end else begin
                exp_rsp = expected_rsps.pop_front();
                status_seen[exp_rsp.status]++;
                if (o_rsp !== exp_rsp) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: id %h/%h rank %0d/%0d count %0d/%0d status %0d/%0d",
                                 exp_rsp.chosen_id, o_rsp.chosen_id, exp_rsp.rank, o_rsp.rank,
                                 exp_rsp.member_count, o_rsp.member_count,
                                 exp_rsp.status, o_rsp.status);
                end
            end
        end
    end

    function automatic t_req make_req(logic [2:0] act, logic [31:0] id, logic [1:0] g);
        t_req r;
        r.action       = act;
        r.member_id    = id;
        r.group        = g;
        r.sequence_req = $urandom;
        r.position     = $urandom_range(255);
        r.is_running   = 1'b1;
        r.name_match   = 1'b1;
        return r;
    endfunction

    // Ids come from a small pool so removes and lookups usually hit.
    function automatic logic [31:0] pool_id();
        int k;
        k = $urandom_range(99);
        if (k < 3) return 32'hFFFF_FFFF;
        if (k < 6) return 32'h0;
        return {$urandom_range(3) == 0 ? 24'($urandom) : 24'h0, 8'($urandom_range(150))};
    endfunction

    initial begin
        t_req r;
        i_rst_n = 1'b0;
        hold_off = 0;
        no_idle = 0;
        mismatch_count = 0;
        transfer_count = 0;
        result_count = 0;
        for (int g = 0; g < 3; g++) member_cnt[g] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-table cases, extreme ids, ignores, unknown codes.
        pending_reqs.push_back(make_req(ACT_ROUTE_PRI, 32'h0, GRP_ALL));
        pending_reqs.push_back(make_req(ACT_NUM_TO_ID, 32'h0, GRP_A));
        pending_reqs.push_back(make_req(ACT_ID_TO_NUM, 32'h5, GRP_B));
        pending_reqs.push_back(make_req(ACT_REMOVE, 32'h5, GRP_A));
        pending_reqs.push_back(make_req(ACT_ADD, 32'hFFFF_FFFF, GRP_A));
        pending_reqs.push_back(make_req(ACT_ADD, 32'h0, GRP_B));
        pending_reqs.push_back(make_req(ACT_ADD, 32'h8000_0000, GRP_BAD));
        pending_reqs.push_back(make_req(ACT_ADD, 32'h8000_0000, GRP_ALL));
        r = make_req(ACT_ADD, 32'h77, GRP_A); r.is_running = 0; pending_reqs.push_back(r);
        r = make_req(ACT_ADD, 32'h77, GRP_A); r.name_match = 0; pending_reqs.push_back(r);
        r = make_req(ACT_REMOVE, 32'h0, GRP_B); r.name_match = 0; pending_reqs.push_back(r);
        r = make_req(ACT_ROUTE_PRI, 32'h0, GRP_ALL); r.sequence_req = 32'hFFFF_FFFF;
        pending_reqs.push_back(r);
        r = make_req(ACT_ROUTE_SEC, 32'h0, GRP_ALL); r.sequence_req = 32'hFFFF_FFFF;
        pending_reqs.push_back(r);
        r = make_req(ACT_NUM_TO_ID, 32'h0, GRP_ALL); r.position = 8'd255; pending_reqs.push_back(r);
        r = make_req(ACT_NUM_TO_ID, 32'h0, GRP_ALL); r.position = 8'd0; pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(ACT_ID_TO_NUM, 32'hFFFF_FFFF, GRP_A));
        pending_reqs.push_back(make_req(ACT_COUNT, 32'h0, GRP_BAD));
        pending_reqs.push_back(make_req(ACT_BAD, 32'hFFFF_FFFF, GRP_A));
        pending_reqs.push_back(make_req(ACT_ADD, 32'h0, GRP_A));
        pending_reqs.push_back(make_req(ACT_REMOVE, 32'h0, GRP_A));
        pending_reqs.push_back(make_req(ACT_REMOVE, 32'h0, GRP_A));

        // Pause until every expected result has come.
        wait (pending_reqs.size() == 0 && !i_start);
        hold_off = 1;
        wait (expected_rsps.size() == 0);
        @(posedge i_clk);
        hold_off = 0;

        // Fill all-members to the brim, 40 of them also in group A, then overflow it.
        no_idle = 1;
        for (int i = 0; i < 66; i++) begin
            r = make_req(ACT_ADD, 32'h1000 + i * 3, (i < 40) ? GRP_A : GRP_ALL);
            pending_reqs.push_back(r);
        end
        pending_reqs.push_back(make_req(ACT_ADD, 32'h0000_0001, GRP_B));
        pending_reqs.push_back(make_req(ACT_ADD, 32'h1000, GRP_A));
        pending_reqs.push_back(make_req(ACT_COUNT, 32'h0, GRP_ALL));
        r = make_req(ACT_NUM_TO_ID, 32'h0, GRP_ALL); r.position = 8'd63; pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(ACT_ROUTE_SEC, 32'h0, GRP_A));
        for (int i = 0; i < 66; i++)
            pending_reqs.push_back(make_req(ACT_REMOVE, 32'h1000 + i * 3, GRP_A));
        wait (pending_reqs.size() == 0);
        no_idle = 0;

        // Random: mostly adds/removes/queries on a small id pool.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            int k;
            k = $urandom_range(99);
            r.action       = (k < 30) ? ACT_ADD : (k < 45) ? ACT_REMOVE :
                             (k < 97) ? 3'($urandom_range(2, 6)) : ACT_BAD;
            r.member_id    = pool_id();
            r.group        = 2'($urandom_range(9) == 0 ? 3 : $urandom_range(2));
            r.sequence_req = $urandom;
            r.position     = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
            r.is_running   = $urandom_range(9) != 0;
            r.name_match   = $urandom_range(9) != 0;
            pending_reqs.push_back(r);
        end
        wait (pending_reqs.size() == 0 && !i_start);
        wait (expected_rsps.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("Ran %0d transfers, %0d results; statuses ok/empty/notfound/full/ignored",
                 transfer_count, result_count);
        $display("  = %0d/%0d/%0d/%0d/%0d, mismatches %0d", status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3], status_seen[4], mismatch_count);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("ERROR: timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
sv/smtr_pkg.sv
sv/smtr_divider.sv
sv/sorted_member_table_modulo_router_core.sv
sim/sorted_member_table_modulo_router_core_tb.sv
